@@ rtl/thumb32_data_proc_decoder_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Thumb-2 data-processing decoder
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef THUMB32_DATA_PROC_DECODER_TOP_ASSERT_SVH
`define THUMB32_DATA_PROC_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define T32DP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define T32DP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/t32dp_pkg.sv @@
// ----------------------------------------------------------------------------
// Thumb-2 data-processing decoder package
// Codes, opcode constants and the decoded-operation record.
// ----------------------------------------------------------------------------
package t32dp_pkg;

  // group selector
  localparam logic [1:0] KIND_MOD_IMM   = 2'd0;
  localparam logic [1:0] KIND_PLAIN_IMM = 2'd1;
  localparam logic [1:0] KIND_SHIFTED   = 2'd2;

  typedef enum logic [2:0] {
    CLS_DP_IMM   = 3'd0,
    CLS_DP_SHIFT = 3'd1,
    CLS_SAT      = 3'd2,
    CLS_BITFIELD = 3'd3,
    CLS_PACK     = 3'd4
  } cls_e;

  typedef enum logic [4:0] {
    OP_AND   = 5'd0,
    OP_BIC   = 5'd1,
    OP_ORR   = 5'd2,
    OP_ORN   = 5'd3,
    OP_EOR   = 5'd4,
    OP_ADD   = 5'd5,
    OP_ADC   = 5'd6,
    OP_SBC   = 5'd7,
    OP_SUB   = 5'd8,
    OP_RSB   = 5'd9,
    OP_TST   = 5'd10,
    OP_TEQ   = 5'd11,
    OP_CMN   = 5'd12,
    OP_CMP   = 5'd13,
    OP_MOV   = 5'd14,
    OP_MVN   = 5'd15,
    OP_PKHBT = 5'd16,
    OP_PKHTB = 5'd17,
    OP_NONE  = 5'd18
  } op_e;

  typedef enum logic [2:0] {
    SHK_LSL = 3'd0,
    SHK_LSR = 3'd1,
    SHK_ASR = 3'd2,
    SHK_ROR = 3'd3,
    SHK_RRX = 3'd4
  } shk_e;

  // 4-bit ALU opcode field, shared by modified-immediate and shifted groups
  localparam logic [3:0] ALU_AND = 4'h0;
  localparam logic [3:0] ALU_BIC = 4'h1;
  localparam logic [3:0] ALU_ORR = 4'h2;
  localparam logic [3:0] ALU_ORN = 4'h3;
  localparam logic [3:0] ALU_EOR = 4'h4;
  localparam logic [3:0] ALU_PKH = 4'h6;
  localparam logic [3:0] ALU_ADD = 4'h8;
  localparam logic [3:0] ALU_ADC = 4'hA;
  localparam logic [3:0] ALU_SBC = 4'hB;
  localparam logic [3:0] ALU_SUB = 4'hD;
  localparam logic [3:0] ALU_RSB = 4'hE;

  // 5-bit opcode field of the plain-immediate group
  localparam logic [4:0] PL_ADDW   = 5'h00;
  localparam logic [4:0] PL_MOVW   = 5'h04;
  localparam logic [4:0] PL_SUBW   = 5'h0A;
  localparam logic [4:0] PL_MOVT   = 5'h0C;
  localparam logic [4:0] PL_SSAT   = 5'h10;
  localparam logic [4:0] PL_SSAT16 = 5'h12;
  localparam logic [4:0] PL_SBFX   = 5'h14;
  localparam logic [4:0] PL_BFI    = 5'h16;
  localparam logic [4:0] PL_USAT   = 5'h18;
  localparam logic [4:0] PL_USAT16 = 5'h1A;
  localparam logic [4:0] PL_UBFX   = 5'h1C;

  localparam logic [3:0] REG_PC   = 4'hF;
  localparam logic [4:0] REG_NONE = 5'd16;

  localparam logic [1:0] TY_ASR = 2'd2;
  localparam logic [1:0] TY_ROR = 2'd3;

  typedef struct packed {
    logic        undefined;
    cls_e        insn_class;
    op_e         operation;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg;
    logic [3:0]  second_reg;
    logic [31:0] immediate;
    logic        sets_flags;
    shk_e        shift_kind;
    logic [4:0]  shift_count;
    logic        signed_op;
  } dec_rec_t;

endpackage

@@ rtl/t32dp_expand_imm.sv @@
// ----------------------------------------------------------------------------
// Modified-immediate expander
// 12-bit encoded constant to 32-bit value: byte replication or rotated byte.
// ----------------------------------------------------------------------------
module t32dp_expand_imm (
  input  logic [11:0] imm12_i,
  output logic [31:0] imm_o
);

  logic [7:0]  byte_w;
  logic [31:0] rot_src;
  logic [63:0] rot_dbl;
  logic [4:0]  rot_amt;

  assign byte_w  = imm12_i[7:0];
  assign rot_src = {24'd0, 1'b1, imm12_i[6:0]};
  assign rot_dbl = {rot_src, rot_src} >> rot_amt;
  assign rot_amt = imm12_i[11:7];

  always_comb begin
    if (imm12_i[11:10] == 2'b00) begin
      case (imm12_i[9:8])
        2'd0:    imm_o = {24'd0, byte_w};
        2'd1:    imm_o = {8'd0, byte_w, 8'd0, byte_w};
        2'd2:    imm_o = {byte_w, 8'd0, byte_w, 8'd0};
        default: imm_o = {byte_w, byte_w, byte_w, byte_w};
      endcase
    end else begin
      // rotate right; amount is 8..31 in this branch
      imm_o = rot_dbl[31:0];
    end
  end

endmodule

@@ rtl/t32dp_decode.sv @@
// ----------------------------------------------------------------------------
// Data-processing decode logic
// One instruction word in, one decoded-operation record out, no state.
// ----------------------------------------------------------------------------
module t32dp_decode (
  input  logic [1:0]          kind_i,
  input  logic [15:0]         first_half_i,
  input  logic [15:0]         second_half_i,
  output t32dp_pkg::dec_rec_t rec_o
);

  logic [3:0]  rn;
  logic [3:0]  rd;
  logic [3:0]  rm;
  logic        s_bit;
  logic [3:0]  alu_opc;
  logic [4:0]  pl_opc;
  logic [11:0] imm12;
  logic [15:0] imm16;
  logic [4:0]  pos;
  logic [4:0]  low5;
  logic [1:0]  ty;
  logic [31:0] mod_imm;
  logic [7:0]  bfi_width;
  logic [7:0]  bfx_width;

  // ALU map results
  logic              alu_ok;
  t32dp_pkg::op_e    alu_op;
  logic              alu_rd_none;
  logic              alu_rn_none;
  logic              cmp_form;

  t32dp_pkg::dec_rec_t rec;
  logic                ok;

  assign rn      = first_half_i[3:0];
  assign s_bit   = first_half_i[4];
  assign alu_opc = first_half_i[8:5];
  assign pl_opc  = first_half_i[8:4];
  assign rd      = second_half_i[11:8];
  assign rm      = second_half_i[3:0];
  assign ty      = second_half_i[5:4];
  assign low5    = second_half_i[4:0];
  assign imm12   = {first_half_i[10], second_half_i[14:12], second_half_i[7:0]};
  assign imm16   = {rn, imm12};
  assign pos     = {second_half_i[14:12], second_half_i[7:6]};
  // BFI width wraps at 8 bits when msb < lsb
  assign bfi_width = {3'd0, low5} - {3'd0, pos} + 8'd1;
  assign bfx_width = {3'd0, low5} + 8'd1;

  t32dp_expand_imm u_expand (
    .imm12_i (imm12),
    .imm_o   (mod_imm)
  );

  assign cmp_form = (rd == t32dp_pkg::REG_PC) && s_bit;

  always_comb begin
    alu_ok      = 1'b1;
    alu_op      = t32dp_pkg::OP_AND;
    alu_rd_none = 1'b0;
    alu_rn_none = 1'b0;
    case (alu_opc)
      t32dp_pkg::ALU_AND: begin
        alu_op      = cmp_form ? t32dp_pkg::OP_TST : t32dp_pkg::OP_AND;
        alu_rd_none = cmp_form;
      end
      t32dp_pkg::ALU_BIC: alu_op = t32dp_pkg::OP_BIC;
      t32dp_pkg::ALU_ORR: begin
        alu_op      = (rn == t32dp_pkg::REG_PC) ? t32dp_pkg::OP_MOV : t32dp_pkg::OP_ORR;
        alu_rn_none = (rn == t32dp_pkg::REG_PC);
      end
      t32dp_pkg::ALU_ORN: begin
        alu_op      = (rn == t32dp_pkg::REG_PC) ? t32dp_pkg::OP_MVN : t32dp_pkg::OP_ORN;
        alu_rn_none = (rn == t32dp_pkg::REG_PC);
      end
      t32dp_pkg::ALU_EOR: begin
        alu_op      = cmp_form ? t32dp_pkg::OP_TEQ : t32dp_pkg::OP_EOR;
        alu_rd_none = cmp_form;
      end
      t32dp_pkg::ALU_ADD: begin
        alu_op      = cmp_form ? t32dp_pkg::OP_CMN : t32dp_pkg::OP_ADD;
        alu_rd_none = cmp_form;
      end
      t32dp_pkg::ALU_ADC: alu_op = t32dp_pkg::OP_ADC;
      t32dp_pkg::ALU_SBC: alu_op = t32dp_pkg::OP_SBC;
      t32dp_pkg::ALU_SUB: begin
        alu_op      = cmp_form ? t32dp_pkg::OP_CMP : t32dp_pkg::OP_SUB;
        alu_rd_none = cmp_form;
      end
      t32dp_pkg::ALU_RSB: alu_op = t32dp_pkg::OP_RSB;
      default:            alu_ok = 1'b0;
    endcase
  end

  always_comb begin
    rec = '0;
    ok  = 1'b1;
    case (kind_i)
      t32dp_pkg::KIND_MOD_IMM: begin
        rec.insn_class = t32dp_pkg::CLS_DP_IMM;
        rec.operation  = alu_op;
        rec.dest_reg   = alu_rd_none ? t32dp_pkg::REG_NONE : {1'b0, rd};
        rec.src_reg    = alu_rn_none ? t32dp_pkg::REG_NONE : {1'b0, rn};
        rec.sets_flags = s_bit;
        rec.immediate  = mod_imm;
        ok             = alu_ok;
      end
      t32dp_pkg::KIND_PLAIN_IMM: begin
        rec.dest_reg = {1'b0, rd};
        case (pl_opc)
          t32dp_pkg::PL_ADDW, t32dp_pkg::PL_SUBW: begin
            rec.insn_class = t32dp_pkg::CLS_DP_IMM;
            rec.operation  = (pl_opc == t32dp_pkg::PL_ADDW) ? t32dp_pkg::OP_ADD
                                                              : t32dp_pkg::OP_SUB;
            rec.src_reg    = {1'b0, rn};
            rec.immediate  = {20'd0, imm12};
          end
          t32dp_pkg::PL_MOVW: begin
            rec.insn_class = t32dp_pkg::CLS_DP_IMM;
            rec.operation  = t32dp_pkg::OP_MOV;
            rec.src_reg    = t32dp_pkg::REG_NONE;
            rec.immediate  = {16'd0, imm16};
          end
          t32dp_pkg::PL_MOVT: begin
            rec.insn_class = t32dp_pkg::CLS_DP_IMM;
            rec.operation  = t32dp_pkg::OP_MOV;
            rec.src_reg    = {1'b0, rd};
            rec.immediate  = {imm16, 16'd0};
          end
          t32dp_pkg::PL_SSAT, t32dp_pkg::PL_SSAT16,
          t32dp_pkg::PL_USAT, t32dp_pkg::PL_USAT16: begin
            rec.insn_class  = t32dp_pkg::CLS_SAT;
            rec.src_reg     = {1'b0, rn};
            rec.immediate   = {27'd0, low5};
            rec.shift_kind  = first_half_i[5] ? t32dp_pkg::SHK_ASR : t32dp_pkg::SHK_LSL;
            rec.shift_count = pos;
            rec.signed_op   = ~pl_opc[3];
          end
          t32dp_pkg::PL_SBFX, t32dp_pkg::PL_BFI, t32dp_pkg::PL_UBFX: begin
            rec.insn_class = t32dp_pkg::CLS_BITFIELD;
            rec.src_reg    = {1'b0, rn};
            rec.signed_op  = (pl_opc == t32dp_pkg::PL_SBFX);
            if (pl_opc == t32dp_pkg::PL_BFI) begin
              rec.immediate = {16'd0, bfi_width, 3'd0, pos};
              // rn of pc encodes BFC
              rec.operation = (rn == t32dp_pkg::REG_PC) ? t32dp_pkg::OP_BIC
                                                         : t32dp_pkg::OP_ORR;
            end else begin
              rec.immediate = {16'd0, bfx_width, 3'd0, pos};
              rec.operation = t32dp_pkg::OP_MOV;
            end
          end
          default: ok = 1'b0;
        endcase
      end
      t32dp_pkg::KIND_SHIFTED: begin
        rec.insn_class  = t32dp_pkg::CLS_DP_SHIFT;
        rec.dest_reg    = {1'b0, rd};
        rec.src_reg     = {1'b0, rn};
        rec.second_reg  = rm;
        rec.sets_flags  = s_bit;
        rec.shift_kind  = t32dp_pkg::shk_e'({1'b0, ty});
        rec.shift_count = pos;
        // ROR by zero encodes RRX
        if ((ty == t32dp_pkg::TY_ROR) && (pos == 5'd0)) begin
          rec.shift_kind  = t32dp_pkg::SHK_RRX;
          rec.shift_count = 5'd1;
        end
        if (alu_opc == t32dp_pkg::ALU_PKH) begin
          rec.insn_class = t32dp_pkg::CLS_PACK;
          rec.operation  = (ty == t32dp_pkg::TY_ASR) ? t32dp_pkg::OP_PKHTB
                                                     : t32dp_pkg::OP_PKHBT;
        end else begin
          rec.operation = alu_op;
          if (alu_rd_none) rec.dest_reg = t32dp_pkg::REG_NONE;
          if (alu_rn_none) rec.src_reg = t32dp_pkg::REG_NONE;
          ok = alu_ok;
        end
      end
      default: ok = 1'b0;
    endcase

    if (!ok) begin
      rec           = '0;
      rec.undefined = 1'b1;
    end
  end

  assign rec_o = rec;

endmodule

@@ rtl/thumb32_data_proc_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Thumb-2 32-bit data-processing decoder, top level
// Datapath: input register, combinational decode, then the result register.
// Throughput: 1 word per cycle while the output is not stalled; stage 1 moves
//   into the result register whenever that register is empty or being drained.
// Reset: rst_ni low clears both stage valid flags; payload is not reset.
// ----------------------------------------------------------------------------
module thumb32_data_proc_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] first_half_i,
  input  logic [15:0] second_half_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        undefined_o,
  output logic [2:0]  insn_class_o,
  output logic [4:0]  operation_o,
  output logic [4:0]  dest_reg_o,
  output logic [4:0]  src_reg_o,
  output logic [3:0]  second_reg_o,
  output logic [31:0] immediate_o,
  output logic        sets_flags_o,
  output logic [2:0]  shift_kind_o,
  output logic [4:0]  shift_count_o,
  output logic        signed_op_o
);

  // Stage 1: captured instruction word
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  kind_q;
  logic [15:0] h1_q;
  logic [15:0] h2_q;

  // Stage 2: decoded record, drives the ports directly
  logic                out_valid_q, out_valid_d;
  t32dp_pkg::dec_rec_t rec_q;
  t32dp_pkg::dec_rec_t rec_d;

  logic s2_load;  // result register takes stage 1 this cycle
  logic s1_load;  // input register takes a new word this cycle

  // The result register frees up when empty or being drained, so a word
  // keeps moving while the previous result is being taken.
  assign s2_load = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_load = in_valid_i && !in_stall_o;

  // Stall only when stage 1 is full and cannot move on.
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s2_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      kind_q <= kind_i;
      h1_q   <= first_half_i;
      h2_q   <= second_half_i;
    end
  end

  t32dp_decode u_decode (
    .kind_i        (kind_q),
    .first_half_i  (h1_q),
    .second_half_i (h2_q),
    .rec_o         (rec_d)
  );

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      rec_q <= rec_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign undefined_o   = rec_q.undefined;
  assign insn_class_o  = rec_q.insn_class;
  assign operation_o   = rec_q.operation;
  assign dest_reg_o    = rec_q.dest_reg;
  assign src_reg_o     = rec_q.src_reg;
  assign second_reg_o  = rec_q.second_reg;
  assign immediate_o   = rec_q.immediate;
  assign sets_flags_o  = rec_q.sets_flags;
  assign shift_kind_o  = rec_q.shift_kind;
  assign shift_count_o = rec_q.shift_count;
  assign signed_op_o   = rec_q.signed_op;

endmodule

@@ rtl/t32dp_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker for the data-processing decoder
// Watches the top-level ports for flow and record consistency.
// ----------------------------------------------------------------------------
`include "thumb32_data_proc_decoder_top_assert.svh"

module t32dp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        undefined_o,
  input logic [2:0]  insn_class_o,
  input logic [4:0]  operation_o,
  input logic [4:0]  dest_reg_o,
  input logic [4:0]  src_reg_o,
  input logic [31:0] immediate_o,
  input logic        sets_flags_o
);

  // a held result word does not change
  `T32DP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(immediate_o) && $stable(dest_reg_o) && $stable(operation_o), "result changed under stall")

  // input backs up only when the result side is full and stalled
  `T32DP_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stall without output stall")

  // an accepted word passes the input register, then the result register, to the output when not blocked
  `T32DP_ASSERT_NEXT(a_latency, (in_valid_i && !in_stall_o) ##1 !out_stall_i, out_valid_o, "accepted word did not reach output")

  // an undefined result carries an all-zero record
  `T32DP_ASSERT_IMPL(a_undef_zero, out_valid_o && undefined_o, insn_class_o == 3'd0 && operation_o == 5'd0 && dest_reg_o == 5'd0 && src_reg_o == 5'd0 && immediate_o == 32'd0 && !sets_flags_o, "undefined result not cleared")

endmodule

bind thumb32_data_proc_decoder_top t32dp_checker u_t32dp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .undefined_o  (undefined_o),
  .insn_class_o (insn_class_o),
  .operation_o  (operation_o),
  .dest_reg_o   (dest_reg_o),
  .src_reg_o    (src_reg_o),
  .immediate_o  (immediate_o),
  .sets_flags_o (sets_flags_o)
);

@@ tb/tb_thumb32_data_proc_decoder_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the Thumb-2 32-bit data-processing decoder
// Directed words hit each group, alias, immediate expansion and reserved
// opcode. Constrained-by-hand random words then run under several idle and
// stall mixes. Each accepted word is decoded by a local model into a queue,
// and every accepted result is checked against the oldest entry.
// ----------------------------------------------------------------------------
module tb_thumb32_data_proc_decoder_top;
  import t32dp_pkg::*;

  // group selector value with no group behind it
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  // opcodes with no instruction behind them
  localparam logic [3:0] ALU_RESERVED = 4'h5;
  localparam logic [4:0] PL_RESERVED  = 5'h01;
  // shift type encodings not named in the package
  localparam logic [1:0] TY_LSL = 2'd0;
  localparam logic [1:0] TY_LSR = 2'd1;

  // opcode pools for the random words, packed so any simulator takes them
  localparam logic [43:0] ALU_OPS = {ALU_AND, ALU_BIC, ALU_ORR, ALU_ORN, ALU_EOR,
                                     ALU_PKH, ALU_ADD, ALU_ADC, ALU_SBC, ALU_SUB,
                                     ALU_RSB};
  localparam logic [54:0] PLAIN_OPS = {PL_ADDW, PL_MOVW, PL_SUBW, PL_MOVT, PL_SSAT,
                                       PL_SSAT16, PL_SBFX, PL_BFI, PL_USAT,
                                       PL_USAT16, PL_UBFX};

  localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 1000;  // cycles without a handshake
  localparam int DRAIN_CYCLES = 6;     // settle time after the last result

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i        = KIND_MOD_IMM;
  logic [15:0] first_half_i  = '0;
  logic [15:0] second_half_i = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic        undefined_o;
  logic [2:0]  insn_class_o;
  logic [4:0]  operation_o;
  logic [4:0]  dest_reg_o;
  logic [4:0]  src_reg_o;
  logic [3:0]  second_reg_o;
  logic [31:0] immediate_o;
  logic        sets_flags_o;
  logic [2:0]  shift_kind_o;
  logic [4:0]  shift_count_o;
  logic        signed_op_o;

  thumb32_data_proc_decoder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .first_half_i  (first_half_i),
    .second_half_i (second_half_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .undefined_o   (undefined_o),
    .insn_class_o  (insn_class_o),
    .operation_o   (operation_o),
    .dest_reg_o    (dest_reg_o),
    .src_reg_o     (src_reg_o),
    .second_reg_o  (second_reg_o),
    .immediate_o   (immediate_o),
    .sets_flags_o  (sets_flags_o),
    .shift_kind_o  (shift_kind_o),
    .shift_count_o (shift_count_o),
    .signed_op_o   (signed_op_o)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shared state
  // --------------------------------------------------------------------------
  dec_rec_t    decoded_q[$];     // decodes still owed by the block, oldest first
  int          n_words;
  int          n_sent;           // words the sender has seen taken
  int          n_results;
  int          n_mismatch;
  int          n_undef;
  int          n_in_held;        // cycles the block held off an offered word
  int          class_hits[5];
  logic [18:0] op_seen = '0;

  bit tx_gaps_on;                // sender inserts idle cycles
  bit rx_gaps_on;                // receiver inserts stall cycles
  bit hold_request;              // ask the receiver for one long hold-off
  int hold_left;
  int stall_left;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Decode model: one word in, one record out
  // --------------------------------------------------------------------------
  function automatic dec_rec_t decode_word(input logic [1:0] kind,
                                           input logic [15:0] h1,
                                           input logic [15:0] h2);
    dec_rec_t    r;
    logic        ok;
    logic        use_alu;
    logic        cmp_form;
    logic        s;
    logic [3:0]  rn;
    logic [3:0]  rd;
    logic [3:0]  alu_opc;
    logic [4:0]  plain_opc;
    logic [11:0] imm12;
    logic [4:0]  pos;
    logic [4:0]  low5;
    logic [7:0]  b;
    logic [7:0]  wid;
    logic [31:0] rot_src;
    logic [63:0] rot_pair;
    r         = '0;
    ok        = 1'b1;
    use_alu   = 1'b0;
    s         = h1[4];
    rn        = h1[3:0];
    rd        = h2[11:8];
    alu_opc   = h1[8:5];
    plain_opc = h1[8:4];
    imm12     = {h1[10], h2[14:12], h2[7:0]};
    pos       = {h2[14:12], h2[7:6]};   // shift amount or bitfield lsb
    low5      = h2[4:0];
    b         = imm12[7:0];

    case (kind)
      KIND_MOD_IMM: begin
        r.insn_class = CLS_DP_IMM;
        r.dest_reg   = {1'b0, rd};
        r.src_reg    = {1'b0, rn};
        r.sets_flags = s;
        if (imm12[11:10] == 2'b00) begin
          // byte replication patterns; a zero byte is legal here
          case (imm12[9:8])
            2'd0:    r.immediate = {24'd0, b};
            2'd1:    r.immediate = {8'd0, b, 8'd0, b};
            2'd2:    r.immediate = {b, 8'd0, b, 8'd0};
            default: r.immediate = {4{b}};
          endcase
        end else begin
          // 1bcdefgh rotated right by imm12[11:7], which is 8..31 here
          rot_src     = {24'd0, 1'b1, imm12[6:0]};
          rot_pair    = {rot_src, rot_src} >> imm12[11:7];
          r.immediate = rot_pair[31:0];
        end
        use_alu = 1'b1;
      end
      KIND_PLAIN_IMM: begin
        r.dest_reg = {1'b0, rd};
        case (plain_opc)
          PL_ADDW, PL_SUBW: begin
            // rn of pc is ADR; the base register reads back as pc either way
            r.insn_class = CLS_DP_IMM;
            r.operation  = (plain_opc == PL_ADDW) ? OP_ADD : OP_SUB;
            r.src_reg    = {1'b0, rn};
            r.immediate  = {20'd0, imm12};
          end
          PL_MOVW: begin
            r.insn_class = CLS_DP_IMM;
            r.operation  = OP_MOV;
            r.src_reg    = REG_NONE;
            r.immediate  = {16'd0, rn, imm12};
          end
          PL_MOVT: begin
            r.insn_class = CLS_DP_IMM;
            r.operation  = OP_MOV;
            r.src_reg    = {1'b0, rd};
            r.immediate  = {rn, imm12, 16'd0};
          end
          PL_SSAT, PL_SSAT16, PL_USAT, PL_USAT16: begin
            // no ALU op: operation stays zero
            r.insn_class  = CLS_SAT;
            r.src_reg     = {1'b0, rn};
            r.immediate   = {27'd0, low5};
            r.shift_kind  = h1[5] ? SHK_ASR : SHK_LSL;
            r.shift_count = pos;
            r.signed_op   = ~h1[7];
          end
          PL_SBFX, PL_BFI, PL_UBFX: begin
            // BFI width is msb - lsb + 1 in 8 bits, so msb < lsb wraps
            if (plain_opc == PL_BFI) wid = {3'd0, low5} - {3'd0, pos} + 8'd1;
            else wid = {3'd0, low5} + 8'd1;
            r.insn_class = CLS_BITFIELD;
            r.src_reg    = {1'b0, rn};
            r.immediate  = {16'd0, wid, 3'd0, pos};
            r.signed_op  = (plain_opc == PL_SBFX);
            if (plain_opc != PL_BFI) r.operation = OP_MOV;
            else r.operation = (rn == REG_PC) ? OP_BIC : OP_ORR;
          end
          default: ok = 1'b0;
        endcase
      end
      KIND_SHIFTED: begin
        r.insn_class  = CLS_DP_SHIFT;
        r.dest_reg    = {1'b0, rd};
        r.src_reg     = {1'b0, rn};
        r.second_reg  = h2[3:0];
        r.sets_flags  = s;
        r.shift_kind  = shk_e'({1'b0, h2[5:4]});
        r.shift_count = pos;
        if (h2[5:4] == TY_ROR && pos == 5'd0) begin
          r.shift_kind  = SHK_RRX;
          r.shift_count = 5'd1;
        end
        if (alu_opc == ALU_PKH) begin
          r.insn_class = CLS_PACK;
          r.operation  = (h2[5:4] == TY_ASR) ? OP_PKHTB : OP_PKHBT;
        end else begin
          use_alu = 1'b1;
        end
      end
      default: ok = 1'b0;
    endcase

    // shared ALU opcode map with compare and move aliases
    if (use_alu) begin
      cmp_form = (rd == REG_PC) && s;
      case (alu_opc)
        ALU_AND: if (cmp_form) begin
          r.operation = OP_TST;
          r.dest_reg  = REG_NONE;
        end else r.operation = OP_AND;
        ALU_BIC: r.operation = OP_BIC;
        ALU_ORR: if (rn == REG_PC) begin
          r.operation = OP_MOV;
          r.src_reg   = REG_NONE;
        end else r.operation = OP_ORR;
        ALU_ORN: if (rn == REG_PC) begin
          r.operation = OP_MVN;
          r.src_reg   = REG_NONE;
        end else r.operation = OP_ORN;
        ALU_EOR: if (cmp_form) begin
          r.operation = OP_TEQ;
          r.dest_reg  = REG_NONE;
        end else r.operation = OP_EOR;
        ALU_ADD: if (cmp_form) begin
          r.operation = OP_CMN;
          r.dest_reg  = REG_NONE;
        end else r.operation = OP_ADD;
        ALU_ADC: r.operation = OP_ADC;
        ALU_SBC: r.operation = OP_SBC;
        ALU_SUB: if (cmp_form) begin
          r.operation = OP_CMP;
          r.dest_reg  = REG_NONE;
        end else r.operation = OP_SUB;
        ALU_RSB: r.operation = OP_RSB;
        default: ok = 1'b0;
      endcase
    end

    if (!ok) begin
      r           = '0;
      r.undefined = 1'b1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: results are checked first, then the new word is decoded, so
  // a stray result on an edge that also takes a word is still caught
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("result %0d: %s expected 0x%0h, got 0x%0h", n_results, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    dec_rec_t want;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        n_results++;
        if (decoded_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("result %0d arrived with nothing outstanding", n_results);
        end else begin
          want = decoded_q.pop_front();
          check_field("undefined",   want.undefined,   undefined_o);
          check_field("insn_class",  want.insn_class,  insn_class_o);
          check_field("operation",   want.operation,   operation_o);
          check_field("dest_reg",    want.dest_reg,    dest_reg_o);
          check_field("src_reg",     want.src_reg,     src_reg_o);
          check_field("second_reg",  want.second_reg,  second_reg_o);
          check_field("immediate",   want.immediate,   immediate_o);
          check_field("sets_flags",  want.sets_flags,  sets_flags_o);
          check_field("shift_kind",  want.shift_kind,  shift_kind_o);
          check_field("shift_count", want.shift_count, shift_count_o);
          check_field("signed_op",   want.signed_op,   signed_op_o);
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        want = decode_word(kind_i, first_half_i, second_half_i);
        decoded_q.push_back(want);
        n_words++;
        if (want.undefined) n_undef++;
        else begin
          class_hits[want.insn_class]++;
          op_seen[want.operation] = 1'b1;
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b1) n_in_held++;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (rx_gaps_on) begin
      stall_left = idle_len();
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles with work pending and no handshake on either side
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0) ||
          (in_valid_i !== 1'b1 && decoded_q.size() == 0))
        quiet = 0;
      else
        quiet++;
    end
    $display("no handshake for %0d cycles with words outstanding", QUIET_LIMIT);
    $display("tb_thumb32_data_proc_decoder_top NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender. Called at a rising edge, returns at the edge that took the word,
  // so back-to-back words never lower and re-raise valid in one step.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [1:0] kind, input logic [15:0] h1,
                           input logic [15:0] h2);
    int gap;
    gap = tx_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    first_half_i  <= h1;
    second_half_i <= h2;
    do @(posedge clk_i); while (!(in_valid_i === 1'b1 && in_stall_o === 1'b0));
    n_sent++;
  endtask

  // modified-immediate encoding: imm12 = i:imm3:imm8
  task automatic send_mod(input logic [3:0] op, input logic s, input logic [3:0] rn,
                          input logic [3:0] rd, input logic [11:0] imm12);
    send_word(KIND_MOD_IMM, {5'b11110, imm12[11], 1'b0, op, s, rn},
              {1'b0, imm12[10:8], rd, imm12[7:0]});
  endtask

  // plain-immediate encoding, same immediate layout
  task automatic send_plain(input logic [4:0] op, input logic [3:0] rn,
                            input logic [3:0] rd, input logic [11:0] imm12);
    send_word(KIND_PLAIN_IMM, {5'b11110, imm12[11], 1'b1, op, rn},
              {1'b0, imm12[10:8], rd, imm12[7:0]});
  endtask

  // shifted-register encoding: n = imm3:imm2
  task automatic send_shf(input logic [3:0] op, input logic s, input logic [3:0] rn,
                          input logic [3:0] rd, input logic [4:0] n,
                          input logic [1:0] ty, input logic [3:0] rm);
    send_word(KIND_SHIFTED, {7'b1110101, op, s, rn}, {1'b0, n[4:2], rd, n[1:0], ty, rm});
  endtask

  // Random word: mostly defined opcodes, with pc and zero-shift fields
  // forced now and then so the aliases and RRX come up often.
  task automatic make_random_word(output logic [1:0] kind, output logic [15:0] h1,
                                  output logic [15:0] h2);
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    if (pick < 36) kind = KIND_MOD_IMM;
    else if (pick < 70) kind = KIND_PLAIN_IMM;
    else if (pick < 97) kind = KIND_SHIFTED;
    else kind = KIND_RESERVED;
    h1 = 16'($urandom_range(0, 16'hFFFF));
    h2 = 16'($urandom_range(0, 16'hFFFF));
    if ($urandom_range(0, 99) < 85) begin
      idx = $urandom_range(0, 10);
      if (kind == KIND_PLAIN_IMM) h1[8:4] = PLAIN_OPS[5*idx +: 5];
      else h1[8:5] = ALU_OPS[4*idx +: 4];
    end
    if ($urandom_range(0, 5) == 0) h1[3:0] = REG_PC;
    if ($urandom_range(0, 5) == 0) begin
      h2[11:8] = REG_PC;
      h1[4]    = 1'b1;
    end
    if ($urandom_range(0, 7) == 0) begin
      h2[14:12] = '0;
      h2[7:6]   = '0;
    end
  endtask

  task automatic send_random(input int count);
    logic [1:0]  kind;
    logic [15:0] h1;
    logic [15:0] h2;
    repeat (count) begin
      make_random_word(kind, h1, h2);
      send_word(kind, h1, h2);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (n_results < n_sent) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_modified_imm();
    send_mod(ALU_AND, 1'b0, 4'd1,   4'd2,   12'h000);  // zero immediate
    send_mod(ALU_AND, 1'b1, 4'd3,   REG_PC, 12'h1A5);  // TST, 00XY00XY
    send_mod(ALU_ORR, 1'b0, REG_PC, 4'd4,   12'h23C);  // MOV, XY00XY00
    send_mod(ALU_ORN, 1'b1, REG_PC, 4'd5,   12'h300);  // MVN, zero byte replicated
    send_mod(ALU_ADD, 1'b1, 4'd6,   REG_PC, 12'hFFF);  // CMN, rotate by 31
    send_mod(ALU_EOR, 1'b1, 4'd14,  4'd7,   12'h400);  // rotate by 8
    drain();
  endtask

  task automatic test_shifted_reg();
    send_shf(ALU_BIC, 1'b0, 4'd0,  4'd0,   5'd0,  TY_LSL, 4'd0);
    send_shf(ALU_ORR, 1'b1, 4'd9,  4'd14,  5'd31, TY_LSR, 4'd15);
    send_shf(ALU_ORN, 1'b0, 4'd2,  4'd3,   5'd17, TY_ASR, 4'd4);
    send_shf(ALU_ADD, 1'b0, 4'd15, 4'd15,  5'd5,  TY_ROR, 4'd8);   // pc, no flags
    send_shf(ALU_ADC, 1'b1, 4'd1,  4'd2,   5'd0,  TY_ROR, 4'd3);   // RRX
    send_shf(ALU_SBC, 1'b0, 4'd4,  4'd5,   5'd1,  TY_LSL, 4'd6);
    send_shf(ALU_SUB, 1'b1, 4'd7,  4'd8,   5'd12, TY_LSR, 4'd9);
    send_shf(ALU_SUB, 1'b1, 4'd10, REG_PC, 5'd3,  TY_ASR, 4'd11);  // CMP
    send_shf(ALU_EOR, 1'b1, 4'd12, REG_PC, 5'd0,  TY_LSL, 4'd13);  // TEQ
    send_shf(ALU_RSB, 1'b1, 4'd14, 4'd1,   5'd31, TY_ROR, 4'd15);
    send_shf(ALU_PKH, 1'b0, 4'd2,  4'd3,   5'd0,  TY_ROR, 4'd4);   // PKHBT, RRX form
    send_shf(ALU_PKH, 1'b1, 4'd5,  4'd6,   5'd31, TY_ASR, 4'd7);   // PKHTB
    drain();
  endtask

  task automatic test_plain_imm();
    send_plain(PL_ADDW,   REG_PC, 4'd0,  12'hFFF);  // ADR
    send_plain(PL_SUBW,   4'd3,   4'd15, 12'h001);
    send_plain(PL_MOVW,   4'hF,   4'd2,  12'hFFF);  // all-ones halfword
    send_plain(PL_MOVT,   4'hA,   4'd9,  12'h5C3);
    send_plain(PL_SSAT,   4'd1,   4'd2,  12'h7DF);  // shift 31, sat 31
    send_plain(PL_USAT16, 4'd3,   4'd4,  12'h000);
    send_plain(PL_SBFX,   4'd6,   4'd7,  12'h01F);  // width 32 at bit 0
    send_plain(PL_BFI,    4'd5,   4'd8,  12'h7C0);  // msb below lsb, width wraps
    send_plain(PL_BFI,    REG_PC, 4'd1,  12'h10B);  // BFC
    send_plain(PL_UBFX,   4'd11,  4'd12, 12'h217);
    drain();
  endtask

  task automatic test_reserved();
    send_mod(ALU_RESERVED, 1'b1, 4'd2, 4'd3, 12'hABC);
    send_plain(PL_RESERVED, 4'd4, 4'd5, 12'hFFF);
    send_word(KIND_RESERVED, 16'hFFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_random(input int count, input bit tx_on, input bit rx_on);
    tx_gaps_on = tx_on;
    rx_gaps_on = rx_on;
    send_random(count);
    drain();
  endtask

  // long receiver hold-off while words keep coming: the pipe fills and the
  // block must hold its input without dropping or duplicating a word
  task automatic test_output_hold();
    tx_gaps_on   = 1'b0;
    rx_gaps_on   = 1'b0;
    hold_request = 1'b1;
    send_random(24);
    drain();
  endtask

  // sender stops dead mid-stream until everything has come back
  task automatic test_sender_pause();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    send_random(16);
    drain();
    send_random(16);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_modified_imm();
    test_shifted_reg();
    test_plain_imm();
    test_reserved();
    test_random(650, 1'b1, 1'b1);
    test_random(400, 1'b0, 1'b0);   // full rate, no idling anywhere
    test_output_hold();
    test_random(400, 1'b0, 1'b1);
    test_sender_pause();
    test_random(400, 1'b1, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("decoded %0d words (%0d undefined), %0d of 18 operations seen",
             n_words, n_undef, $countones(op_seen[17:0]));
    $display("class mix imm/shift/sat/bitfield/pack %0d/%0d/%0d/%0d/%0d, input held %0d cycles",
             class_hits[0], class_hits[1], class_hits[2], class_hits[3], class_hits[4],
             n_in_held);
    if (n_mismatch == 0) begin
      $display("tb_thumb32_data_proc_decoder_top OK");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("tb_thumb32_data_proc_decoder_top NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/t32dp_pkg.sv
rtl/t32dp_expand_imm.sv
rtl/t32dp_decode.sv
rtl/thumb32_data_proc_decoder_top.sv
rtl/t32dp_checker.sv
tb/tb_thumb32_data_proc_decoder_top.sv
